// ===== design/bgis_pkg.sv =====
// ----------------------------------------------------------------------------
// bgis_pkg: shared types, constants and gamma tables
// Holds the store geometry, command codes, status codes and the decode and
// encode threshold tables built at elaboration.
// ----------------------------------------------------------------------------
package bgis_pkg;

    localparam int MAX_WIDTH         = 256;
    localparam int MAX_HEIGHT        = 256;
    localparam int ENCODE_INDEX_BITS = 12;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CLR_W  = 16 - ENCODE_INDEX_BITS;

    // register indexes
    localparam logic [2:0] REG_IMG_W = 3'd0;
    localparam logic [2:0] REG_IMG_H = 3'd1;
    localparam logic [2:0] REG_INV   = 3'd2;
    localparam logic [2:0] REG_OUT_W = 3'd3;
    localparam logic [2:0] REG_OUT_H = 3'd4;

    // input operations
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // result status
    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_OOR  = 2'd2;

    // command kinds between front and back
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SKIP = 2'd1;
    localparam logic [1:0] CMD_SAMP = 2'd2;

    localparam logic [2:0] TAG_FINAL = 3'd4;

    typedef logic signed [19:0] t_smp;
    typedef logic signed [27:0] t_res;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic [ROW_W-1:0]  iy;
        logic [COL_W-1:0]  ix;
        logic [15:0]       fy;
        logic [15:0]       fx;
        logic [HD_W-1:0]   h;
        logic [WD_W-1:0]   w;
    } t_cmd;

    typedef logic [255:0][16:0] t_tab;

    function automatic longint unsigned fifth_chain(longint unsigned r);
        longint unsigned p;
        p = r << 16;
        for (int n = 0; n < 4; n++) begin
            p = (p * r) >> 16;
        end
        return p;
    endfunction

    // shift-subtract quotient for the elaboration-time tables
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [16:0] gamma_pow(longint unsigned num, longint unsigned den,
                                              bit up);
        longint unsigned lo, hi, mid, n2, d2, q;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (fifth_chain(mid) * den <= (num << 32)) lo = mid;
            else hi = mid - 1;
        end
        n2 = num * num * lo;
        d2 = den * den;
        q  = up ? udiv(n2 + d2 - 1, d2) : udiv(n2 + (d2 >> 1), d2);
        return q[16:0];
    endfunction

    function automatic t_tab build_dec();
        t_tab t;
        for (int v = 0; v < 256; v++) begin
            t[v] = gamma_pow(longint'(v), 64'd255, 1'b0);
        end
        return t;
    endfunction

    function automatic t_tab build_enc();
        t_tab t;
        t[0] = '0;
        for (int v = 1; v < 256; v++) begin
            t[v] = gamma_pow(longint'(2 * v - 1), 64'd510, 1'b1);
        end
        return t;
    endfunction

    localparam t_tab DEC_TAB = build_dec();
    localparam t_tab ENC_TAB = build_enc();

endpackage

// ===== design/bgis_if.sv =====
// ----------------------------------------------------------------------------
// bgis_if: input and output channels of the scaler
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bgis_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;

    modport source (output valid, op, row, col, red_in, green_in, blue_in, alpha_in,
                    input ready);
    modport sink   (input valid, op, row, col, red_in, green_in, blue_in, alpha_in,
                    output ready);
endinterface

interface bgis_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [1:0] status;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, status,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, status,
                    output ready);
endinterface

// ===== design/bgis_front.sv =====
// ----------------------------------------------------------------------------
// bgis_front: configuration and word classification
// Holds the registers, maps sample coordinates to the source grid and
// turns each accepted word into a load, skip or sample command.
// ----------------------------------------------------------------------------
module bgis_front
    import bgis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    bgis_in_if.sink     i_in,
    output logic        o_cmd_v,
    output t_cmd        o_cmd,
    input  logic        i_cmd_rdy
);

    logic [8:0]  r_img_w, r_img_h;
    logic [23:0] r_inv;
    logic [12:0] r_out_w, r_out_h;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
            r_inv   <= 24'd65536;
            r_out_w <= 13'd256;
            r_out_h <= 13'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMG_W: r_img_w <= i_cfg_data[8:0];
                REG_IMG_H: r_img_h <= i_cfg_data[8:0];
                REG_INV:   r_inv   <= i_cfg_data;
                REG_OUT_W: r_out_w <= i_cfg_data[12:0];
                REG_OUT_H: r_out_h <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [12:0] wv, hv, w, h;
    logic [35:0] sy, sx;
    logic [19:0] iy, ix;
    logic        load_oor, samp_oor;

    // clamp dimensions, map coordinates and classify
    always_comb begin
        wv = {4'b0, r_img_w};
        hv = {4'b0, r_img_h};
        w  = (wv == 13'd0) ? 13'd1 : ((wv > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : wv);
        h  = (hv == 13'd0) ? 13'd1 : ((hv > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : hv);
        sy = {24'b0, i_in.row} * {12'b0, r_inv};
        sx = {24'b0, i_in.col} * {12'b0, r_inv};
        iy = sy[35:16];
        ix = sx[35:16];
        load_oor = ({1'b0, i_in.row} >= 13'(MAX_HEIGHT)) ||
                   ({1'b0, i_in.col} >= 13'(MAX_WIDTH));
        samp_oor = ({1'b0, i_in.row} >= r_out_h) || ({1'b0, i_in.col} >= r_out_w) ||
                   (iy >= {7'b0, h}) || (ix >= {7'b0, w});

        o_cmd.addr = ADDR_W'(i_in.row[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'(i_in.col[COL_W-1:0]);
        o_cmd.data = {i_in.alpha_in, i_in.blue_in, i_in.green_in, i_in.red_in};
        o_cmd.iy   = iy[ROW_W-1:0];
        o_cmd.ix   = ix[COL_W-1:0];
        o_cmd.fy   = sy[15:0];
        o_cmd.fx   = sx[15:0];
        o_cmd.h    = h[HD_W-1:0];
        o_cmd.w    = w[WD_W-1:0];
        if (i_in.op == OP_LOAD) o_cmd.kind = load_oor ? CMD_SKIP : CMD_LOAD;
        else                    o_cmd.kind = samp_oor ? CMD_SKIP : CMD_SAMP;
    end

    assign o_cmd_v    = i_in.valid;
    assign i_in.ready = i_cmd_rdy;

endmodule

// ===== design/bgis_queue.sv =====
// ----------------------------------------------------------------------------
// bgis_queue: two-entry command queue
// Decouples the front from the back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module bgis_queue
    import bgis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_v,
    input  t_cmd i_push,
    output logic o_push_rdy,
    output logic o_pop_v,
    output t_cmd o_pop,
    input  logic i_pop_rdy
);

    t_cmd       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_push_rdy = (r_cnt != 2'd2);
    assign o_pop_v    = (r_cnt != 2'd0);
    assign o_pop      = r_ent[r_rp];
    assign push       = i_push_v && o_push_rdy;
    assign pop        = o_pop_v && i_pop_rdy;

    // store pushed words
    always_ff @(posedge i_clk) begin
        if (push) r_ent[r_wp] <= i_push;
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/bgis_cubic.sv =====
// ----------------------------------------------------------------------------
// bgis_cubic: three-channel Catmull-Rom unit
// One multiply per channel per cycle over the a, b and c steps; a final step
// rounds and writes the result. A new start is taken in the cycle the previous result is written.
// ----------------------------------------------------------------------------
module bgis_cubic
    import bgis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_tag,
    input  t_smp        i_p [3][4],
    input  logic [15:0] i_x,
    input  logic [15:0] i_x2,
    input  logic [15:0] i_x3,
    output logic        o_done,
    output logic [2:0]  o_tag,
    output t_res        o_v [3]
);

    logic signed [23:0] r_a [3], r_b [3], r_c [3];
    t_smp               r_p1 [3];
    logic signed [43:0] r_acc [3];
    logic [15:0]        r_x, r_x2, r_x3;
    logic [2:0]         r_tag, r_step;
    logic               r_done;
    logic [2:0]         r_otag;
    t_res               r_v [3];

    logic signed [23:0] a [3], b [3], c [3];
    logic signed [23:0] mop [3];
    logic signed [16:0] xop;
    logic signed [43:0] prod [3], rnd [3];

    // coefficients from the four samples
    always_comb begin
        for (int q = 0; q < 3; q++) begin
            a[q] = -24'(i_p[q][0]) + 24'sd3 * 24'(i_p[q][1])
                   - 24'sd3 * 24'(i_p[q][2]) + 24'(i_p[q][3]);
            b[q] = 24'sd2 * 24'(i_p[q][0]) - 24'sd5 * 24'(i_p[q][1])
                   + 24'sd4 * 24'(i_p[q][2]) - 24'(i_p[q][3]);
            c[q] = 24'(i_p[q][2]) - 24'(i_p[q][0]);
        end
    end

    // select the term of this step
    always_comb begin
        unique case (r_step)
            3'd1:    xop = $signed({1'b0, r_x3});
            3'd2:    xop = $signed({1'b0, r_x2});
            default: xop = $signed({1'b0, r_x});
        endcase
        for (int q = 0; q < 3; q++) begin
            unique case (r_step)
                3'd1:    mop[q] = r_a[q];
                3'd2:    mop[q] = r_b[q];
                default: mop[q] = r_c[q];
            endcase
            prod[q] = 44'(mop[q] * xop);
            rnd[q]  = (r_acc[q] + 44'sd65536) >>> 17;
        end
    end

    // latch operands and accumulate terms
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= a;
            r_b  <= b;
            r_c  <= c;
            r_x  <= i_x;
            r_x2 <= i_x2;
            r_x3 <= i_x3;
            r_tag <= i_tag;
            for (int q = 0; q < 3; q++) r_p1[q] <= i_p[q][1];
        end
        for (int q = 0; q < 3; q++) begin
            if (r_step == 3'd1)
                r_acc[q] <= prod[q];
            else if (r_step == 3'd2 || r_step == 3'd3)
                r_acc[q] <= r_acc[q] + prod[q];
            if (r_step == 3'd4)
                r_v[q] <= 28'(r_p1[q]) + rnd[q][27:0];
        end
        if (r_step == 3'd4) r_otag <= r_tag;
    end

    // step the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == 3'd4);
            if (i_start)
                r_step <= 3'd1;
            else if (r_step != 3'd0 && r_step != 3'd4)
                r_step <= r_step + 3'd1;
            else
                r_step <= 3'd0;
        end
    end

    assign o_done = r_done;
    assign o_tag  = r_otag;
    assign o_v    = r_v;

endmodule

// ===== design/bgis_back.sv =====
// ----------------------------------------------------------------------------
// bgis_back: pixel store and sample sequencer
// Executes loads, reads the sixteen neighbours of a sample, drives the cubic
// unit over rows then columns, and encodes the result with a bit search.
// ----------------------------------------------------------------------------
module bgis_back
    import bgis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_v,
    input  t_cmd        i_cmd,
    output logic        o_cmd_rdy,
    bgis_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POW1  = 3'd1;
    localparam logic [2:0] S_POW2  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WAITR = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_WAITF = 3'd6;
    localparam logic [2:0] S_ENC   = 3'd7;

    logic [2:0]  r_state;
    t_cmd        r_cmd;
    logic [15:0] r_fx2, r_fy2, r_fx3, r_fy3;
    logic [3:0]  r_cnt;

    logic [31:0] r_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [31:0] r_rdata;
    logic        r_rd_v, r_rd_in;
    logic [3:0]  r_rd_idx;
    logic [7:0]  r_alpha;

    t_smp        r_nb [3][4];
    t_smp        r_rows [3][4];
    logic        r_go;
    logic [2:0]  r_go_tag;

    logic [16:0] r_ev [3];
    logic [7:0]  r_code [3];
    logic [2:0]  r_bit;

    logic        r_ov;
    logic [7:0]  r_red, r_green, r_blue, r_aout;
    logic [1:0]  r_status;

    logic        pop, mem_we;
    logic [31:0] pfx2, pfy2, pfx3, pfy3;
    logic [ROW_W+1:0] ry;
    logic [COL_W+1:0] rx;
    logic        nb_in;
    logic [ADDR_W-1:0] rd_addr;

    logic        cm_start, cm_done;
    logic [2:0]  cm_tag;
    t_smp        cm_p [3][4];
    logic [15:0] cm_x, cm_x2, cm_x3;
    t_res        cm_v [3];

    logic [16:0] clamp [3];
    logic [7:0]  cand;

    assign pop       = (r_state == S_IDLE) && i_cmd_v && !r_ov;
    assign o_cmd_rdy = (r_state == S_IDLE) && !r_ov;
    assign mem_we    = pop && (i_cmd.kind == CMD_LOAD);

    // powers of the fractions
    assign pfx2 = {16'b0, r_cmd.fx} * {16'b0, r_cmd.fx};
    assign pfy2 = {16'b0, r_cmd.fy} * {16'b0, r_cmd.fy};
    assign pfx3 = {16'b0, r_fx2} * {16'b0, r_cmd.fx};
    assign pfy3 = {16'b0, r_fy2} * {16'b0, r_cmd.fy};

    // neighbour position and bounds for this read
    always_comb begin
        ry = {2'b00, r_cmd.iy} + {{ROW_W{1'b0}}, r_cnt[3:2]} - 1'b1;
        rx = {2'b00, r_cmd.ix} + {{COL_W{1'b0}}, r_cnt[1:0]} - 1'b1;
        nb_in = !ry[ROW_W+1] && !rx[COL_W+1] &&
                ((ROW_W + 2)'(r_cmd.h) > ry) && ((COL_W + 2)'(r_cmd.w) > rx);
        rd_addr = ADDR_W'(ry[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx[COL_W-1:0]);
    end

    // single-port pixel store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[i_cmd.addr] <= i_cmd.data;
        else        r_rdata <= r_mem[rd_addr];
    end

    // track read data and decode neighbours
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_READ);
            r_go   <= r_rd_v && (r_rd_idx[1:0] == 2'd3);
        end
        r_rd_idx <= r_cnt;
        r_rd_in  <= nb_in;
        r_go_tag <= {1'b0, r_rd_idx[3:2]};
        if (r_rd_v) begin
            for (int q = 0; q < 3; q++)
                r_nb[q][r_rd_idx[1:0]] <= r_rd_in ?
                    t_smp'({3'b0, DEC_TAB[r_rdata[8*q +: 8]]}) : '0;
            if (r_rd_idx == 4'd5) r_alpha <= r_rdata[31:24];
        end
    end

    // feed the cubic unit
    always_comb begin
        cm_start = r_go || (r_state == S_FINAL);
        if (r_state == S_FINAL) begin
            cm_p  = r_rows;
            cm_x  = r_cmd.fy;
            cm_x2 = r_fy2;
            cm_x3 = r_fy3;
        end else begin
            cm_p  = r_nb;
            cm_x  = r_cmd.fx;
            cm_x2 = r_fx2;
            cm_x3 = r_fx3;
        end
    end

    bgis_cubic u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cm_start),
        .i_tag   (r_state == S_FINAL ? TAG_FINAL : r_go_tag),
        .i_p     (cm_p),
        .i_x     (cm_x),
        .i_x2    (cm_x2),
        .i_x3    (cm_x3),
        .o_done  (cm_done),
        .o_tag   (cm_tag),
        .o_v     (cm_v)
    );

    // clamp to [0,1] and drop the low encode bits
    always_comb begin
        for (int q = 0; q < 3; q++) begin
            if (cm_v[q][27])
                clamp[q] = '0;
            else if (cm_v[q] > 28'sd65536)
                clamp[q] = 17'd65536;
            else
                clamp[q] = cm_v[q][16:0];
            clamp[q] = (clamp[q] >> CLR_W) << CLR_W;
        end
        cand = 8'd1 << r_bit;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            CMD_LOAD: begin
                                r_ov <= 1'b1;
                                r_status <= ST_LOAD;
                            end
                            CMD_SAMP: r_state <= S_POW1;
                            default: begin
                                r_ov <= 1'b1;
                                r_status <= ST_OOR;
                            end
                        endcase
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                        r_aout  <= '0;
                    end
                end
                S_POW1: begin
                    r_fx2   <= pfx2[31:16];
                    r_fy2   <= pfy2[31:16];
                    r_state <= S_POW2;
                end
                S_POW2: begin
                    r_fx3   <= pfx3[31:16];
                    r_fy3   <= pfy3[31:16];
                    r_cnt   <= 4'd0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_state <= S_WAITR;
                end
                S_WAITR: begin
                    if (cm_done && cm_tag == 3'd3) r_state <= S_FINAL;
                end
                S_FINAL: r_state <= S_WAITF;
                S_WAITF: begin
                    if (cm_done && cm_tag == TAG_FINAL) begin
                        r_ev    <= clamp;
                        r_code  <= '{default: 8'd0};
                        r_bit   <= 3'd7;
                        r_state <= S_ENC;
                    end
                end
                S_ENC: begin
                    for (int q = 0; q < 3; q++)
                        if (ENC_TAB[r_code[q] | cand] <= r_ev[q])
                            r_code[q] <= r_code[q] | cand;
                    r_bit <= r_bit - 3'd1;
                    if (r_bit == 3'd0) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // final encode step writes the result
            if (r_state == S_ENC && r_bit == 3'd0) begin
                r_ov     <= 1'b1;
                r_status <= ST_OK;
                r_red    <= (ENC_TAB[r_code[0] | cand] <= r_ev[0]) ? (r_code[0] | cand)
                                                                   : r_code[0];
                r_green  <= (ENC_TAB[r_code[1] | cand] <= r_ev[1]) ? (r_code[1] | cand)
                                                                   : r_code[1];
                r_blue   <= (ENC_TAB[r_code[2] | cand] <= r_ev[2]) ? (r_code[2] | cand)
                                                                   : r_code[2];
                r_aout   <= r_alpha;
            end
        end
    end

    // hold row results from the cubic unit
    always_ff @(posedge i_clk) begin
        if (cm_done && cm_tag != TAG_FINAL)
            for (int q = 0; q < 3; q++) r_rows[q][cm_tag[1:0]] <= t_smp'(cm_v[q]);
    end

    assign o_out.valid     = r_ov;
    assign o_out.red_out   = r_red;
    assign o_out.green_out = r_green;
    assign o_out.blue_out  = r_blue;
    assign o_out.alpha_out = r_aout;
    assign o_out.status    = r_status;

endmodule

// ===== design/bicubic_gamma_image_scaler_top.sv =====
// ----------------------------------------------------------------------------
// bicubic_gamma_image_scaler_top: gamma-correct bicubic RGBA scaler
// Front classifies words, a two-entry queue decouples it from the back,
// which holds the pixel store and interpolates samples.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake    | word
//   i_in     | in  | valid/ready  | op, row, col, red/green/blue/alpha in
//   o_out    | out | valid/ready  | red/green/blue/alpha out, status
//   i_cfg_*  | in  | write enable | register index, data
//
// A load or an out-of-range word writes its result straight from the idle state. A
// sample goes from its pop through the fraction powers (POW1, POW2), sixteen
// reads from the single-port pixel store, the row and column passes of the
// cubic unit and an eight-step encode search to its result. Reset clears
// control state only; the pixel store holds no reset value. While a result waits
// on o_out the back takes no command, and the queue accepts words until it is full.
// ----------------------------------------------------------------------------
module bicubic_gamma_image_scaler_top
    import bgis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    bgis_in_if.sink     i_in,
    bgis_out_if.source  o_out
);

    logic f_v, f_rdy, b_v, b_rdy;
    t_cmd f_cmd, b_cmd;

    bgis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_cmd_v    (f_v),
        .o_cmd      (f_cmd),
        .i_cmd_rdy  (f_rdy)
    );

    bgis_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_v   (f_v),
        .i_push     (f_cmd),
        .o_push_rdy (f_rdy),
        .o_pop_v    (b_v),
        .o_pop      (b_cmd),
        .i_pop_rdy  (b_rdy)
    );

    bgis_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_v   (b_v),
        .i_cmd     (b_cmd),
        .o_cmd_rdy (b_rdy),
        .o_out     (o_out)
    );

endmodule
